// ===== hdl/hs_pkg.sv =====
// Package for the contrast stretch core: action codes, register indexes, states and constants.
package hs_pkg;

  typedef enum logic [1:0] {
    ACT_RESTART = 2'd0,
    ACT_MEASURE = 2'd1,
    ACT_MAP     = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_OUT_LOW  = 2'd0,
    REG_OUT_HIGH = 2'd1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MULT,
    ST_DIV,
    ST_DONE
  } state_t;

  localparam int unsigned GREY_W = 8;

  // Scaling by 105/100 and 95/100 as one multiply by k*5243 and a shift by 19,
  // which is exact over the 8-bit input range.
  localparam int unsigned SCALE_SHIFT = 19;
  localparam logic [19:0] DARK_MUL    = 20'd550515;
  localparam logic [19:0] BRIGHT_MUL  = 20'd498085;

  localparam int unsigned NUM_W       = 18;
  localparam int unsigned DIGIT_W     = 2;
  localparam int unsigned DIV_CYCLES  = NUM_W / DIGIT_W;
  localparam int unsigned CNT_W       = $clog2(DIV_CYCLES);

  localparam logic [GREY_W-1:0] DARK_RESET   = 8'd255;
  localparam logic [GREY_W-1:0] BRIGHT_RESET = 8'd0;
  localparam logic [GREY_W-1:0] LOW_RESET    = 8'd0;
  localparam logic [GREY_W-1:0] HIGH_RESET   = 8'd255;

endpackage

// ===== hdl/histogram_stretch_core.sv =====
// Two-pass min/max grey-level contrast stretch with a radix-4 serial divider.
// A map item is scaled in ST_LOAD, multiplied in ST_MULT, divided in ST_DIV by the
// two-bit-per-cycle divider and written out in ST_DONE; ST_DIV is skipped with equal scaled
// bounds. The core takes no new item until it is back in ST_IDLE, and a stalled result delays
// the next one. Measure and restart items are taken in ST_IDLE and need no further states.
// Reset (rst, sync, active high): out_low 0, out_high 255, darkest 255, brightest 0, no result.
module histogram_stretch_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] pixel,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] stretched,
  output logic       divide_error,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  hs_pkg::state_t state, state_next;

  logic [7:0] out_low, out_high, darkest, brightest;
  logic [7:0] pix;
  logic [8:0] dk;
  logic [7:0] br;
  logic       num_neg, err;
  logic [hs_pkg::NUM_W-1:0] nq;
  logic [8:0] dmag, rem;
  logic [hs_pkg::CNT_W-1:0] cnt;

  logic in_take, map_take, out_load;
  logic [27:0] dk_prod;
  logic [26:0] br_prod;
  logic signed [9:0]  diff, den;
  logic signed [8:0]  span;
  logic signed [18:0] prod;
  logic [17:0] prod_mag;
  logic [8:0]  den_mag;
  logic [9:0]  t0, t1;
  logic [8:0]  r0, r1;
  logic        q0, q1;
  logic signed [18:0] qs;
  logic signed [19:0] sum;
  logic [7:0]  res;

  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign map_take  = in_take && (action == hs_pkg::ACT_MAP);

  always_comb begin
    state_next = state;
    unique case (state)
      hs_pkg::ST_IDLE: if (map_take) state_next = hs_pkg::ST_LOAD;
      hs_pkg::ST_LOAD: state_next = hs_pkg::ST_MULT;
      hs_pkg::ST_MULT: state_next = (den == 10'sd0) ? hs_pkg::ST_DONE : hs_pkg::ST_DIV;
      hs_pkg::ST_DIV: begin
        if (cnt == hs_pkg::CNT_W'(hs_pkg::DIV_CYCLES - 1)) state_next = hs_pkg::ST_DONE;
      end
      hs_pkg::ST_DONE: if (!out_valid || !out_stall) state_next = hs_pkg::ST_IDLE;
      default: state_next = hs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (state)
      hs_pkg::ST_IDLE: in_stall = 1'b0;
      hs_pkg::ST_DONE: out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  assign dk_prod  = 28'(darkest) * 28'(hs_pkg::DARK_MUL);
  assign br_prod  = 27'(brightest) * 27'(hs_pkg::BRIGHT_MUL);
  assign diff     = $signed({2'b00, pix}) - $signed({1'b0, dk});
  assign den      = $signed({2'b00, br}) - $signed({1'b0, dk});
  assign span     = $signed({1'b0, out_high}) - $signed({1'b0, out_low});
  assign prod     = 19'(diff) * 19'(span);
  assign prod_mag = prod[18] ? 18'(-prod) : prod[17:0];
  assign den_mag  = den[9] ? 9'(-den) : den[8:0];

  always_comb begin
    t0 = {rem, nq[hs_pkg::NUM_W-1]};
    q0 = (t0 >= {1'b0, dmag});
    r0 = q0 ? 9'(t0 - {1'b0, dmag}) : t0[8:0];
    t1 = {r0, nq[hs_pkg::NUM_W-2]};
    q1 = (t1 >= {1'b0, dmag});
    r1 = q1 ? 9'(t1 - {1'b0, dmag}) : t1[8:0];
  end

  always_comb begin
    qs  = num_neg ? -$signed({1'b0, nq}) : $signed({1'b0, nq});
    sum = 20'(qs) + $signed({12'd0, out_low});
    if (err) begin
      res = out_low;
    end else if (sum > 20'sd255) begin
      res = 8'd255;
    end else if (sum < 20'sd0) begin
      res = 8'd0;
    end else begin
      res = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hs_pkg::ST_IDLE;
      out_low   <= hs_pkg::LOW_RESET;
      out_high  <= hs_pkg::HIGH_RESET;
      darkest   <= hs_pkg::DARK_RESET;
      brightest <= hs_pkg::BRIGHT_RESET;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == hs_pkg::REG_OUT_LOW) out_low <= cfg_data;
        if (cfg_index == hs_pkg::REG_OUT_HIGH) out_high <= cfg_data;
      end
      if (in_take && action == hs_pkg::ACT_RESTART) begin
        darkest   <= pixel;
        brightest <= pixel;
      end else if (in_take && action == hs_pkg::ACT_MEASURE) begin
        if (pixel < darkest) darkest <= pixel;
        if (pixel > brightest) brightest <= pixel;
      end
      if (state == hs_pkg::ST_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (map_take) pix <= pixel;
    if (state == hs_pkg::ST_LOAD) begin
      dk <= dk_prod[hs_pkg::SCALE_SHIFT+8:hs_pkg::SCALE_SHIFT];
      br <= br_prod[hs_pkg::SCALE_SHIFT+7:hs_pkg::SCALE_SHIFT];
    end
    if (state == hs_pkg::ST_MULT) begin
      nq      <= prod_mag;
      num_neg <= prod[18] ^ den[9];
      dmag    <= den_mag;
      rem     <= '0;
      err     <= (den == 10'sd0);
    end
    if (state == hs_pkg::ST_DIV) begin
      nq  <= {nq[hs_pkg::NUM_W-3:0], q0, q1};
      rem <= r1;
    end
    if (out_load) begin
      stretched    <= res;
      divide_error <= err;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    state == hs_pkg::ST_DONE && !err |-> rem < dmag)
    else $error("Divider remainder not below divisor.");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == hs_pkg::ST_DONE)
    else $error("Result item appeared without a finished map item.");

  assert property (@(posedge clk) disable iff (rst)
    state == hs_pkg::ST_MULT |=> state == hs_pkg::ST_DIV || (state == hs_pkg::ST_DONE && err))
    else $error("Divider skipped without a zero divisor.");

endmodule

// ===== tb/tb_histogram_stretch_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for histogram_stretch_core: directed frames, then random frames.
module tb_histogram_stretch_core;

  localparam int IDLE_LIMIT = 3000;
  localparam int ITEM_TARGET = 1800;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [7:0] grey;
    logic       div_err;
  } stretch_res_t;

  class stretch_book;
    logic [7:0] tgt_low;
    logic [7:0] tgt_high;
    logic [7:0] dark;
    logic [7:0] bright;
    stretch_res_t due[$];
    int errors;
    int checked;
    int div_errs;

    function new();
      tgt_low = hs_pkg::LOW_RESET;
      tgt_high = hs_pkg::HIGH_RESET;
      dark = hs_pkg::DARK_RESET;
      bright = hs_pkg::BRIGHT_RESET;
      errors = 0;
      checked = 0;
      div_errs = 0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    function void set_reg(hs_pkg::reg_index_t idx, logic [7:0] val);
      if (idx == hs_pkg::REG_OUT_LOW) begin
        tgt_low = val;
      end else if (idx == hs_pkg::REG_OUT_HIGH) begin
        tgt_high = val;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void note_input(hs_pkg::action_t act, logic [7:0] p);
      int dk, br, den, num, lo, hi, res;
      stretch_res_t r;
      case (act)
        hs_pkg::ACT_RESTART, hs_pkg::ACT_MEASURE: begin
          if (act == hs_pkg::ACT_RESTART) begin
            dark = hs_pkg::DARK_RESET;
            bright = hs_pkg::BRIGHT_RESET;
          end
          if (p > bright) bright = p;
          if (p < dark) dark = p;
        end
        hs_pkg::ACT_MAP: begin
          lo = int'(tgt_low);
          hi = int'(tgt_high);
          dk = int'(dark);
          br = int'(bright);
          dk = dk * 105 / 100;
          br = br * 95 / 100;
          den = br - dk;
          if (den == 0) begin
            r.grey = tgt_low;
            r.div_err = 1'b1;
          end else begin
            num = int'(p);
            num = (num - dk) * (hi - lo);
            res = num / den + lo;
            if (res > 255) res = 255;
            if (res < 0) res = 0;
            r.grey = res[7:0];
            r.div_err = 1'b0;
          end
          due.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task check_result(logic [7:0] grey, logic div_err);
      stretch_res_t r;
      if (due.size() == 0) begin
        report($sformatf("unexpected result stretched=%0d divide_error=%b", grey, div_err));
      end else begin
        r = due.pop_front();
        checked++;
        if (r.div_err) div_errs++;
        if (grey !== r.grey) begin
          report($sformatf("stretched %0d, expected %0d", grey, r.grey));
        end
        if (div_err !== r.div_err) begin
          report($sformatf("divide_error %b, expected %b", div_err, r.div_err));
        end
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] action = hs_pkg::ACT_NONE;
  logic [7:0] pixel = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] stretched;
  logic       divide_error;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = hs_pkg::REG_OUT_LOW;
  logic [7:0] cfg_data = 8'd0;

  stretch_book book = new();
  bit steady = 1'b0;
  int items_sent = 0;
  int settings = 0;
  int idle_cycles = 0;

  histogram_stretch_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .pixel(pixel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stretched(stretched),
    .divide_error(divide_error),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles", IDLE_LIMIT);
        $display("FAIL histogram_stretch_core");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_item(hs_pkg::action_t act, logic [7:0] p);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    pixel <= p;
    do @(posedge clk); while (in_stall);
    book.note_input(act, p);
    if (act != hs_pkg::ACT_NONE) items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_targets(logic [7:0] lo, logic [7:0] hi);
    cfg_valid <= 1'b1;
    cfg_index <= hs_pkg::REG_OUT_LOW;
    cfg_data <= lo;
    do @(posedge clk); while (!cfg_ready);
    book.set_reg(hs_pkg::REG_OUT_LOW, lo);
    cfg_index <= hs_pkg::REG_OUT_HIGH;
    cfg_data <= hi;
    do @(posedge clk); while (!cfg_ready);
    book.set_reg(hs_pkg::REG_OUT_HIGH, hi);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic logic [7:0] near_grey(int base, int spread);
    int v;
    v = base + $urandom_range(0, spread);
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic send_noise();
    send_item(hs_pkg::action_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
  endtask

  task automatic run_frame();
    int base, spread, n_meas, n_map;
    base = $urandom_range(0, 255);
    case ($urandom_range(0, 3))
      0: spread = $urandom_range(0, 3);
      1: spread = $urandom_range(4, 30);
      default: spread = 255;
    endcase
    send_item(hs_pkg::ACT_RESTART, near_grey(base, spread));
    n_meas = $urandom_range(0, 15);
    repeat (n_meas) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_item(hs_pkg::ACT_MEASURE, near_grey(base, spread));
    end
    n_map = $urandom_range(1, 15);
    repeat (n_map) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_item(hs_pkg::ACT_MAP, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        out_stall <= 1'b1;
        if ($urandom_range(0, 1) == 1) begin
          do @(posedge clk); while (!out_valid);
          gap--;
        end
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      book.check_result(stretched, divide_error);
    end
  end

  initial begin
    int frames;
    logic [7:0] lo, hi;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Maps before any measurement, then an ignored code.
    send_item(hs_pkg::ACT_MAP, 8'd0);
    send_item(hs_pkg::ACT_MAP, 8'd255);
    send_item(hs_pkg::ACT_NONE, 8'd255);
    // A single measured level gives inverted scaled bounds.
    send_item(hs_pkg::ACT_RESTART, 8'd100);
    send_item(hs_pkg::ACT_MAP, 8'd100);
    send_item(hs_pkg::ACT_MAP, 8'd0);
    // All-black frame gives equal scaled bounds.
    send_item(hs_pkg::ACT_RESTART, 8'd0);
    send_item(hs_pkg::ACT_MAP, 8'd7);
    send_item(hs_pkg::ACT_MEASURE, 8'd255);
    send_item(hs_pkg::ACT_MAP, 8'd0);
    send_item(hs_pkg::ACT_MAP, 8'd255);
    send_item(hs_pkg::ACT_MAP, 8'd128);
    send_item(hs_pkg::ACT_NONE, 8'd0);
    send_item(hs_pkg::ACT_MAP, 8'd200);
    drain();
    set_targets(8'd255, 8'd0);
    send_item(hs_pkg::ACT_MAP, 8'd0);
    send_item(hs_pkg::ACT_MAP, 8'd255);
    send_item(hs_pkg::ACT_MAP, 8'd100);
    drain();
    set_targets(8'd255, 8'd255);
    send_item(hs_pkg::ACT_MAP, 8'd60);
    drain();
    set_targets(8'd0, 8'd0);
    send_item(hs_pkg::ACT_MAP, 8'd60);
    send_item(hs_pkg::ACT_RESTART, 8'd10);
    send_item(hs_pkg::ACT_MEASURE, 8'd11);
    send_item(hs_pkg::ACT_MAP, 8'd10);

    while (items_sent < ITEM_TARGET) begin
      drain();
      case ($urandom_range(0, 5))
        0: begin lo = 8'd0; hi = 8'd255; end
        1: begin lo = 8'd255; hi = 8'd0; end
        2: begin lo = 8'd0; hi = 8'd0; end
        3: begin lo = 8'd255; hi = 8'd255; end
        default: begin lo = 8'($urandom_range(0, 255)); hi = 8'($urandom_range(0, 255)); end
      endcase
      set_targets(lo, hi);
      steady = ($urandom_range(0, 3) == 0);
      frames = $urandom_range(2, 6);
      repeat (frames) run_frame();
    end

    steady = 1'b0;
    drain();
    $display("Sent %0d items over %0d target settings.", items_sent, settings);
    $display("Checked %0d stretched results, %0d with equal scaled bounds.",
             book.checked, book.div_errs);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("PASS histogram_stretch_core");
    end else begin
      $display("%0d mismatches, %0d results never seen", book.errors, book.pending());
      $display("FAIL histogram_stretch_core");
    end
    $finish;
  end
endmodule

// ===== histogram_stretch_core.f =====
hdl/hs_pkg.sv
hdl/histogram_stretch_core.sv
tb/tb_histogram_stretch_core.sv
